// ----- rtl/core/curve_inverse_lookup_defines.svh -----
// Assertion macros shared by the lookup block.
`ifndef CURVE_INVERSE_LOOKUP_DEFINES_SVH
`define CURVE_INVERSE_LOOKUP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define CIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cil_pkg.sv -----
package cil_pkg;

  localparam int CIL_MAX_KEYS = 256;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;
  localparam int QUO_W   = 34;
  localparam int DIV_STEPS = QUO_W / 2;

  // input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_KEY_COUNT  = 1'b0;
  localparam logic CFG_DESCENDING = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // memory read address select
  localparam logic [1:0] RD_MID = 2'd0;
  localparam logic [1:0] RD_A   = 2'd1;
  localparam logic [1:0] RD_B   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       start;
    logic [1:0] rd_sel;
    logic       step;
    logic       cap_a;
    logic       cap_b;
    logic       diff;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       rnd;
    logic       out_load;
    logic       few;
  } cil_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic cnt_zero;
    logic flat;
    logic div_last;
    logic out_busy;
  } cil_sts_t;

endpackage

// ----- rtl/core/cil_ram.sv -----
module cil_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/cil_ctrl.sv -----
module cil_ctrl import cil_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_stall,
  input  cil_sts_t sts,
  output cil_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_CAPB = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_DVI  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_RND  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       few_r, few_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      few_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      few_r   <= few_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    few_nxt   = few_r;
    cmd       = '0;
    cmd.few   = few_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_command == CMD_LOAD) begin
          cmd.load = 1'b1;
        end else if (in_valid) begin
          cmd.start = 1'b1;
          few_nxt   = sts.n_lt2;
          state_nxt = sts.n_lt2 ? S_OUT : S_SRD;
        end
      end
      S_SRD: begin
        // search done: fetch the key before the found one
        if (sts.cnt_zero) begin
          cmd.rd_sel = RD_A;
          state_nxt  = S_RDB;
        end else begin
          cmd.rd_sel = RD_MID;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.step  = 1'b1;
        state_nxt = S_SRD;
      end
      S_RDB: begin
        cmd.rd_sel = RD_B;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.flat ? S_OUT : S_DVI;
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          few_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/cil_dpath.sv -----
module cil_dpath import cil_pkg::*; #(
  parameter int MAX_KEYS = CIL_MAX_KEYS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cil_cmd_t                  cmd,
  output cil_sts_t                  sts,
  input  logic [COUNT_W-1:0]        key_count,
  input  logic                      descending,
  input  logic [7:0]                in_key_index,
  input  logic signed [DATA_W-1:0]  in_key_value,
  input  logic signed [DATA_W-1:0]  in_key_time,
  input  logic signed [DATA_W-1:0]  in_query_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_time_result,
  output logic [1:0]                out_status
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int KW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int CW = $clog2(DIV_STEPS);
  localparam int PW = 2 * DATA_W;
  localparam int MW = QUO_W + 1;
  localparam int SW = MW + 1;
  localparam logic signed [SW-1:0] RES_MAX = SW'(33'sh0_7FFF_FFFF);
  localparam logic signed [SW-1:0] RES_MIN = SW'(33'sh1_8000_0000);

  // one restoring division step: {quotient bit, remainder}
  function automatic logic [DATA_W:0] div_bit(input logic [DATA_W-1:0] rem,
                                              input logic             din,
                                              input logic [DATA_W-1:0] d);
    logic [DATA_W:0] r2;
    r2 = {rem, din};
    if (r2 >= {1'b0, d}) begin
      div_bit = {1'b1, DATA_W'(r2 - {1'b0, d})};
    end else begin
      div_bit = {1'b0, r2[DATA_W-1:0]};
    end
  endfunction

  // key memory: {value, time}
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [2*DATA_W-1:0]   rd_data;

  cil_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_key_value, in_key_time}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign wr_en   = cmd.load && (32'(in_key_index) < 32'(MAX_KEYS));
  assign wr_addr = AW'(in_key_index);

  // key count clamped to the table
  logic [KW-1:0] n_w;
  always_comb begin
    n_w = (KW'(key_count) > KW'(MAX_KEYS)) ? KW'(MAX_KEYS) : KW'(key_count);
  end

  // search state
  logic signed [DATA_W-1:0] qv_r;
  logic [AW-1:0] first_r, first_nxt, count_r, count_nxt, half_w, mid_w;
  logic signed [DATA_W-1:0] rd_value_w;
  logic past_w;

  assign half_w     = count_r >> 1;
  assign mid_w      = first_r + half_w;
  assign rd_value_w = rd_data[2*DATA_W-1:DATA_W];
  assign past_w     = descending ? (qv_r < rd_value_w) : (qv_r > rd_value_w);

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:  rd_addr = mid_w;
      RD_A:    rd_addr = first_r - AW'(1);
      RD_B:    rd_addr = first_r;
      default: rd_addr = first_r;
    endcase
  end

  always_comb begin
    first_nxt = first_r;
    count_nxt = count_r;
    if (cmd.start) begin
      first_nxt = AW'(1);
      count_nxt = AW'(n_w - KW'(2));
    end else if (cmd.step) begin
      if (past_w) begin
        first_nxt = mid_w + AW'(1);
        count_nxt = count_r - half_w - AW'(1);
      end else begin
        count_nxt = half_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    count_r <= count_nxt;
    if (cmd.start) begin
      qv_r <= in_query_value;
    end
  end

  // neighbouring keys
  logic signed [DATA_W-1:0] va_r, ta_r, vb_r, tb_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      va_r <= rd_data[2*DATA_W-1:DATA_W];
      ta_r <= rd_data[DATA_W-1:0];
    end
    if (cmd.cap_b) begin
      vb_r <= rd_data[2*DATA_W-1:DATA_W];
      tb_r <= rd_data[DATA_W-1:0];
    end
  end

  // differences as sign and magnitude
  logic signed [DATA_W:0] num_w, dt_w, dv_w;
  logic [DATA_W-1:0] num_mag_r, dt_mag_r, d_r;
  logic neg_r, flat_r;

  always_comb begin
    num_w = (DATA_W+1)'(qv_r) - (DATA_W+1)'(va_r);
    dt_w  = (DATA_W+1)'(tb_r) - (DATA_W+1)'(ta_r);
    dv_w  = (DATA_W+1)'(vb_r) - (DATA_W+1)'(va_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      num_mag_r <= num_w[DATA_W] ? DATA_W'(-num_w) : DATA_W'(num_w);
      dt_mag_r  <= dt_w[DATA_W]  ? DATA_W'(-dt_w)  : DATA_W'(dt_w);
      d_r       <= dv_w[DATA_W]  ? DATA_W'(-dv_w)  : DATA_W'(dv_w);
      neg_r     <= num_w[DATA_W] ^ dt_w[DATA_W] ^ dv_w[DATA_W];
      flat_r    <= (dv_w == '0);
    end
  end

  // product and serial divider, two quotient bits a cycle
  logic [PW-1:0]         prod_r;
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt, shift_r;
  logic                  ovf_r;
  logic [CW-1:0]         div_cnt_r;
  logic [MW-1:0]         m_r;
  logic [DATA_W:0]       st1_w, st2_w;

  always_comb begin
    st1_w   = div_bit(rem_r, shift_r[QUO_W-1], d_r);
    st2_w   = div_bit(st1_w[DATA_W-1:0], shift_r[QUO_W-2], d_r);
    rem_nxt = st2_w[DATA_W-1:0];
    quo_nxt = {quo_r[QUO_W-3:0], st1_w[DATA_W], st2_w[DATA_W]};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PW'(num_mag_r) * PW'(dt_mag_r);
    end
    if (cmd.div_init) begin
      // quotient needs more than QUO_W bits: the sum saturates anyway
      ovf_r     <= (DATA_W'(prod_r[PW-1:QUO_W]) >= d_r);
      rem_r     <= DATA_W'(prod_r[PW-1:QUO_W]);
      shift_r   <= prod_r[QUO_W-1:0];
      quo_r     <= '0;
      div_cnt_r <= CW'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
      shift_r   <= shift_r << 2;
      div_cnt_r <= div_cnt_r - CW'(1);
    end
    if (cmd.rnd) begin
      // round half away from zero on the magnitude
      if (ovf_r) begin
        m_r <= MW'(1) << QUO_W;
      end else begin
        m_r <= MW'(quo_r) + MW'(({1'b0, rem_r} << 1) >= {1'b0, d_r});
      end
    end
  end

  // final sum, saturation and output register
  logic signed [SW-1:0] ta_ext_w, m_ext_w, sum_w;
  logic signed [DATA_W-1:0] res_w;
  logic [1:0] stat_w;
  logic out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_time_r;
  logic [1:0] out_status_r;

  always_comb begin
    ta_ext_w = SW'(ta_r);
    m_ext_w  = $signed({1'b0, m_r});
    sum_w    = neg_r ? (ta_ext_w - m_ext_w) : (ta_ext_w + m_ext_w);
    res_w    = sum_w[DATA_W-1:0];
    stat_w   = ST_OK;
    if (cmd.few) begin
      res_w  = '0;
      stat_w = ST_FEW;
    end else if (flat_r) begin
      res_w  = ta_r;
    end else if (sum_w > RES_MAX) begin
      res_w  = RES_MAX[DATA_W-1:0];
      stat_w = ST_SAT;
    end else if (sum_w < RES_MIN) begin
      res_w  = RES_MIN[DATA_W-1:0];
      stat_w = ST_SAT;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.out_load) begin
      out_time_r   <= res_w;
      out_status_r <= stat_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_time_result = out_time_r;
  assign out_status      = out_status_r;

  assign sts.n_lt2    = (n_w < KW'(2));
  assign sts.cnt_zero = (count_r == '0);
  assign sts.flat     = flat_r;
  assign sts.div_last = (div_cnt_r == '0);
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// ----- rtl/core/curve_inverse_lookup.sv -----
// Channel  Handshake              Beat contents
// in       in_valid / in_stall    command, key_index, key_value, key_time, query_value
// out      out_valid / out_stall  time_result, status
// cfg      cfg_valid / cfg_ready  cfg_index (0 key_count, 1 descending), cfg_data
//
// A load is written to the table at the edge that accepts its beat.
// A query runs s <= ceil(log2(n-1)) search steps through the single memory read port,
// then the divider, which retires two quotient bits a cycle; the input stalls until
// the result is loaded into the output register. Too few keys sends the query straight
// to the output state; a flat segment skips the divider.
// Reset clears control only; a stalled result holds the output register and the next
// beat is still taken, but its result waits behind the stalled one.
`include "curve_inverse_lookup_defines.svh"

module curve_inverse_lookup import cil_pkg::*; #(
  parameter int MAX_KEYS = CIL_MAX_KEYS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input beats
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [7:0]                in_key_index,
  input  logic signed [DATA_W-1:0]  in_key_value,
  input  logic signed [DATA_W-1:0]  in_key_time,
  input  logic signed [DATA_W-1:0]  in_query_value,
  // result beats
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_time_result,
  output logic [1:0]                out_status,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [COUNT_W-1:0]        cfg_data
);

  // configuration registers, always ready; the user writes them only while idle, unchecked by the block
  logic [COUNT_W-1:0] key_count_r;
  logic               descending_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r  <= '0;
      descending_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_COUNT:  key_count_r  <= cfg_data;
        CFG_DESCENDING: descending_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cil_cmd_t cmd;
  cil_sts_t sts;

  // sequence the search, the divider and the result hand-off
  cil_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // key table, search pointers, arithmetic and output register
  cil_dpath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .key_count       (key_count_r),
    .descending      (descending_r),
    .in_key_index    (in_key_index),
    .in_key_value    (in_key_value),
    .in_key_time     (in_key_time),
    .in_query_value  (in_query_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_time_result (out_time_result),
    .out_status      (out_status)
  );

  // beat and result qualifiers for the checks below
  logic query_beat_w, status_known_w, few_out_w, sat_out_w, at_rail_w;

  assign query_beat_w   = in_valid && !in_stall && (in_command == CMD_QUERY);
  assign status_known_w = (out_status == ST_OK) || (out_status == ST_FEW) ||
                          (out_status == ST_SAT);
  assign few_out_w      = out_valid && (out_status == ST_FEW);
  assign sat_out_w      = out_valid && (out_status == ST_SAT);
  assign at_rail_w      = (out_time_result == 32'sh7FFF_FFFF) ||
                          (out_time_result == 32'sh8000_0000);

  // a query beat must close the input until its result is formed
  `CIL_ASSERT_NEXT(a_query_stalls, query_beat_w, in_stall, "query beat did not stall the input")
  // only defined status codes leave the block
  `CIL_ASSERT_NOW(a_status_code, out_valid, status_known_w, "undefined status code")
  // too few keys always reports time zero
  `CIL_ASSERT_NOW(a_few_zero, few_out_w, out_time_result == '0, "too-few result not zero")
  // saturation reports one of the range limits
  `CIL_ASSERT_NOW(a_sat_limit, sat_out_w, at_rail_w, "saturated result off the limits")

endmodule

// ----- dv/curve_lookup_monitor.sv -----
module curve_lookup_monitor import cil_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_command,
  input  logic [7:0]                in_key_index,
  input  logic signed [DATA_W-1:0]  in_key_value,
  input  logic signed [DATA_W-1:0]  in_key_time,
  input  logic signed [DATA_W-1:0]  in_query_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [DATA_W-1:0]  out_time_result,
  input  logic [1:0]                out_status,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [COUNT_W-1:0]        cfg_data,
  output int unsigned               results_due,
  output int unsigned               failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint       INT32_HI = 64'sd2147483647;
  localparam longint       INT32_LO = -64'sd2147483648;
  localparam logic [127:0] QUO_CAP  = 128'd1 << 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] time_result;
    logic [1:0]               status;
  } crossing_t;

  logic signed [DATA_W-1:0] key_values [CIL_MAX_KEYS];
  logic signed [DATA_W-1:0] key_times  [CIL_MAX_KEYS];
  logic [COUNT_W-1:0]       key_count_q;
  logic                     descending_q;
  crossing_t                due_crossings [$];
  crossing_t                due;
  int unsigned              mismatch_count = 0;

  // Time at which the curve crosses the query value, found on the segment
  // that the binary search lands on.
  function automatic crossing_t invert_curve(logic signed [DATA_W-1:0] query);
    crossing_t    ans;
    int unsigned  n, lo, span, half, mid;
    longint       va, vb, ta, tb, num, dt, gap, res;
    logic [127:0] mnum, mdt, mgap, prod, quo, rem;
    bit           flip;
    ans.status = ST_OK;
    n = (key_count_q > CIL_MAX_KEYS) ? CIL_MAX_KEYS : key_count_q;
    if (n < 2) begin
      ans.time_result = '0;
      ans.status      = ST_FEW;
      return ans;
    end
    lo   = 1;
    span = n - 2;
    while (span > 0) begin
      half = span / 2;
      mid  = lo + half;
      if (descending_q ? (query < key_values[mid]) : (query > key_values[mid])) begin
        lo   = mid + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    va  = key_values[lo-1];
    vb  = key_values[lo];
    ta  = key_times[lo-1];
    tb  = key_times[lo];
    gap = vb - va;
    if (gap == 0) begin
      res = ta;
    end else begin
      num  = longint'(query) - va;
      dt   = tb - ta;
      flip = ((num < 0) != (dt < 0)) != (gap < 0);
      mnum = (num < 0) ? -num : num;
      mdt  = (dt < 0) ? -dt : dt;
      mgap = (gap < 0) ? -gap : gap;
      prod = mnum * mdt;
      quo  = prod / mgap;
      rem  = prod % mgap;
      // round half away from zero, unless already far out of range
      if (quo >= QUO_CAP) quo = QUO_CAP;
      else if (rem >= mgap - rem) quo = quo + 1;
      res = flip ? ta - longint'(quo) : ta + longint'(quo);
    end
    if (res > INT32_HI) begin
      res        = INT32_HI;
      ans.status = ST_SAT;
    end else if (res < INT32_LO) begin
      res        = INT32_LO;
      ans.status = ST_SAT;
    end
    ans.time_result = res[DATA_W-1:0];
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_count_q  = '0;
      descending_q = 1'b0;
      due_crossings.delete();
    end else begin
      // retire results first; a query never answers in its own cycle
      if (out_valid && !out_stall) begin
        if (due_crossings.size() == 0) begin
          $error("time_result: unexpected beat, got %0d with status %0d",
                 out_time_result, out_status);
          mismatch_count++;
        end else begin
          due = due_crossings.pop_front();
          if (out_time_result !== due.time_result) begin
            $error("time_result: expected %0d, got %0d", due.time_result, out_time_result);
            mismatch_count++;
          end
          if (out_status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_status);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_COUNT:  key_count_q  = cfg_data;
          CFG_DESCENDING: descending_q = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_command == CMD_LOAD) begin
          key_values[in_key_index] = in_key_value;
          key_times[in_key_index]  = in_key_time;
        end else begin
          due_crossings.push_back(invert_curve(in_query_value));
        end
      end
    end
    results_due <= due_crossings.size();
    failures    <= mismatch_count;
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import cil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 11;
  localparam int          ITEMS         = 1600;
  // quiet stretch at the end of the run: no gaps, no stalls
  localparam int          CALM_ITEMS    = 200;
  // idle wait after the last result, with headroom over a full-table query
  localparam int          SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam longint      INT32_HI      = 64'sd2147483647;
  localparam longint      INT32_LO      = -64'sd2147483648;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_command;
  logic [7:0]                in_key_index;
  logic signed [DATA_W-1:0]  in_key_value;
  logic signed [DATA_W-1:0]  in_key_time;
  logic signed [DATA_W-1:0]  in_query_value;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_time_result;
  logic [1:0]                out_status;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [COUNT_W-1:0]        cfg_data;
  int unsigned               results_due;
  int unsigned               failures;

  int unsigned beats_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned keys_live   = 0;
  bit          gaps_on     = 1'b1;
  bit          calm        = 1'b0;
  // rising copy of the current curve's values, before any reversal
  longint      curve_rise [CIL_MAX_KEYS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  curve_inverse_lookup DUT (.*);

  curve_lookup_monitor monitor (.*);

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side back-pressure: random bursts of stalled cycles, none when calm or with gaps off.
  always @(posedge clk) begin
    if (stall_left == 0 && gaps_on && !calm && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > INT32_HI) return INT32_HI;
    if (v < INT32_LO) return INT32_LO;
    return v;
  endfunction

  // Present one beat and hold it, unchanged, until the block takes it.
  // An optional idle burst goes in front.
  task automatic put_beat(logic cmd, logic [7:0] idx, logic signed [DATA_W-1:0] kv,
                          logic signed [DATA_W-1:0] kt, logic signed [DATA_W-1:0] qv);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_key_index   <= idx;
    in_key_value   <= kv;
    in_key_time    <= kt;
    in_query_value <= qv;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
  endtask

  // Unused fields of a beat carry random bits so every input bit toggles.
  task automatic load_key(logic [7:0] idx, logic signed [DATA_W-1:0] kv,
                          logic signed [DATA_W-1:0] kt);
    put_beat(CMD_LOAD, idx, kv, kt, int'($urandom()));
  endtask

  task automatic ask(logic signed [DATA_W-1:0] qv);
    put_beat(CMD_QUERY, 8'($urandom()), int'($urandom()), int'($urandom()), qv);
  endtask

  // Drop valid and wait until every predicted result has come out, then
  // give any load still in flight time to land.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Keep valid high across back-to-back writes; the caller lowers it.
  task automatic write_reg(logic idx, logic [COUNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Reprogram both registers, in random order, with the block idle.
  // Spare bits of the direction write are random; only bit 0 counts.
  task automatic configure(logic [COUNT_W-1:0] count, logic desc);
    logic [COUNT_W-1:0] dir_word;
    settle();
    dir_word = {8'($urandom()), desc};
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_KEY_COUNT, count);
      write_reg(CFG_DESCENDING, dir_word);
    end else begin
      write_reg(CFG_DESCENDING, dir_word);
      write_reg(CFG_KEY_COUNT, count);
    end
    cfg_valid <= 1'b0;
    keys_live = (count > CIL_MAX_KEYS) ? CIL_MAX_KEYS : count;
  endtask

  // Load every live slot with a monotonic curve: full range, narrow steps
  // (exercises rounding) or medium steps, with some flat segments. Times are
  // a mix of extremes, slow ramps and noise.
  task automatic fill_curve(logic desc);
    longint      v, stepmax, t_run, kt;
    int unsigned i, slot;
    bit          upward;
    if (keys_live == 0) return;
    case ($urandom_range(0, 3))
      0: begin
        v       = INT32_LO;
        stepmax = 64'd4294967295 / keys_live;
      end
      1: begin
        v       = longint'(int'($urandom()));
        stepmax = $urandom_range(1, 1 << 18);
      end
      default: begin
        v       = longint'(int'($urandom()));
        stepmax = $urandom_range(1, 1 << 24);
      end
    endcase
    for (i = 0; i < keys_live; i++) begin
      curve_rise[i] = v;
      if ($urandom_range(0, 5) != 0)
        v = clamp32(v + longint'($urandom_range(0, 32'(stepmax))));
    end
    upward = $urandom_range(0, 3) != 0;
    t_run  = longint'(int'($urandom())) >>> 4;
    for (i = 0; i < keys_live; i++) begin
      slot = upward ? i : keys_live - 1 - i;
      case ($urandom_range(0, 7))
        0:       kt = INT32_LO;
        1:       kt = INT32_HI;
        2, 3: begin
          t_run = clamp32(t_run + longint'($urandom_range(0, 1 << 20)));
          kt    = t_run;
        end
        default: kt = longint'(int'($urandom()));
      endcase
      load_key(8'(slot), 32'(desc ? curve_rise[keys_live-1-slot] : curve_rise[slot]), 32'(kt));
    end
  endtask

  // Query on a key, next to one, inside the span, at a rail, or anywhere at all.
  task automatic ask_somewhere();
    longint      q, lo, hi;
    int unsigned k;
    if (keys_live == 0) begin
      q = longint'(int'($urandom()));
    end else begin
      k  = $urandom_range(0, keys_live - 1);
      lo = curve_rise[0];
      hi = curve_rise[keys_live-1];
      case ($urandom_range(0, 7))
        0, 1:    q = curve_rise[k];
        2:       q = curve_rise[k] + longint'($urandom_range(0, 6)) - 3;
        3, 4, 5: q = lo + longint'($urandom_range(0, 32'(hi - lo)));
        6:       q = $urandom_range(0, 1) ? INT32_HI : INT32_LO;
        default: q = longint'(int'($urandom()));
      endcase
    end
    ask(32'(clamp32(q)));
  endtask

  task automatic random_phase();
    logic [COUNT_W-1:0] count;
    int unsigned        pick;
    logic               desc;
    pick = $urandom_range(0, 39);
    if (pick < 3)       count = COUNT_W'($urandom_range(0, 1));
    else if (pick == 3) count = COUNT_W'($urandom_range(64, 511));
    else                count = COUNT_W'($urandom_range(2, 24));
    desc    = 1'($urandom_range(0, 1));
    calm    = (beats_sent + CALM_ITEMS >= ITEMS);
    gaps_on = $urandom_range(0, 3) != 0;
    configure(count, desc);
    fill_curve(desc);
    // interleave stray loads; inside the table they break the ordering
    repeat ($urandom_range(4, 30)) begin
      if ($urandom_range(0, 9) == 0)
        load_key(8'($urandom()), int'($urandom()), int'($urandom()));
      ask_somewhere();
    end
  endtask

  initial begin
    logic full_desc;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_LOAD;
    in_key_index   <= '0;
    in_key_value   <= '0;
    in_key_time    <= '0;
    in_query_value <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_KEY_COUNT;
    cfg_data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Too few keys: empty table straight out of reset, then a single key.
    ask(32'sd0);
    configure(9'd1, 1'b0);
    ask(32'(INT32_LO));

    // Two keys, rising: exact midpoint ties round away from zero both ways,
    // extrapolation past either end, and queries at both rails.
    configure(9'd2, 1'b0);
    load_key(8'd0, 32'sd0, 32'sd0);
    load_key(8'd1, 32'sd2, 32'sd1);
    ask(32'sd1);
    ask(-32'sd1);
    ask(32'sd3);
    ask(32'(INT32_HI));
    ask(32'(INT32_LO));

    // Flat segment: equal neighbours answer with the earlier time.
    load_key(8'd1, 32'sd0, 32'(INT32_HI));
    ask(32'sd5);

    // Three keys, falling, spanning the whole value and time range.
    configure(9'd3, 1'b1);
    load_key(8'd0, 32'(INT32_HI), 32'(INT32_LO));
    load_key(8'd1, 32'sd0, 32'sd0);
    load_key(8'd2, 32'(INT32_LO), 32'(INT32_HI));
    ask(32'(INT32_HI));
    ask(32'(INT32_LO));
    ask(32'sh40000000);
    ask(-32'sd5);

    // Largest count the register holds: clipped to a full table.
    full_desc = 1'($urandom_range(0, 1));
    configure(9'd511, full_desc);
    fill_curve(full_desc);
    repeat (40) ask_somewhere();

    // Random phases until the item budget is spent; the tail runs calm.
    while (beats_sent < ITEMS) random_phase();
    settle();

    if (failures == 0 && results_due == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cil_pkg.sv
rtl/core/cil_ram.sv
rtl/core/cil_ctrl.sv
rtl/core/cil_dpath.sv
rtl/core/curve_inverse_lookup.sv
dv/curve_lookup_monitor.sv
dv/tb_top.sv
